### hdl/c_source_tokenizer_macros.svh
// Assertion helpers shared by the tokenizer RTL.
// Synthesis builds get empty bodies.
`ifndef C_SOURCE_TOKENIZER_MACROS_SVH
`define C_SOURCE_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every rising edge outside reset
`define CTOK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("c_source_tokenizer: property violated");

// cond must never be seen at a rising edge outside reset
`define CTOK_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("c_source_tokenizer: forbidden condition seen");

`else

`define CTOK_ASSERT(lbl, clk, rst, prop)
`define CTOK_NEVER(lbl, clk, rst, cond)

`endif

`endif

### hdl/c_tok_pkg.sv
package c_tok_pkg;

   // token classes
   localparam logic [1:0] CLS_IDENT = 2'd0;
   localparam logic [1:0] CLS_OTHER = 2'd1;
   localparam logic [1:0] CLS_PP    = 2'd2;
   localparam logic [1:0] CLS_STR   = 2'd3;

   // characters of interest
   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_LF         = 8'h0A;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_DQUOTE     = 8'h22;
   localparam logic [7:0] CHAR_HASH       = 8'h23;
   localparam logic [7:0] CHAR_SQUOTE     = 8'h27;
   localparam logic [7:0] CHAR_STAR       = 8'h2A;
   localparam logic [7:0] CHAR_SLASH      = 8'h2F;
   localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CHAR_BACKSLASH  = 8'h5C;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;

   // configuration
   localparam int          CSR_ADDR_WIDTH  = 3;
   localparam int          CSR_DATA_WIDTH  = 32;
   localparam int          MAX_LEN_WIDTH   = 9;
   localparam logic [8:0]  MAX_LEN_RESET   = 9'd100;
   localparam logic [8:0]  MAX_LEN_LOW     = 9'd2;
   localparam logic [8:0]  MAX_LEN_HIGH    = 9'd256;
   localparam logic [0:0]  REG_MAX_LEN     = 1'b0;

   // result queue
   localparam int RESULT_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] char_out;
      logic       has_char;
      logic [1:0] token_class;
      logic       first_of_token;
      logic       last_of_token;
      logic       last_result;
   } tok_rslt_type;

   // up to two results produced by one accepted beat
   typedef struct packed {
      logic [1:0]   count;
      tok_rslt_type r0;
      tok_rslt_type r1;
   } tok_push_type;

   function automatic tok_rslt_type mk_rslt(input logic [7:0] ch, input logic has,
                                            input logic [1:0] cls, input logic first,
                                            input logic last);
      tok_rslt_type r;
      r.char_out       = has ? ch : 8'h00;
      r.has_char       = has;
      r.token_class    = cls;
      r.first_of_token = first;
      r.last_of_token  = last;
      r.last_result    = 1'b0;
      return r;
   endfunction

endpackage

### hdl/c_tok_csr.sv
module c_tok_csr
   import c_tok_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output logic [7:0]                char_limit
);

   logic [MAX_LEN_WIDTH-1:0] max_len_ff;
   logic [MAX_LEN_WIDTH-1:0] max_len_clamped;
   logic                     reg_hit;
   logic                     wr_en;

   // one register, word address in paddr[2]
   assign reg_hit = (paddr[CSR_ADDR_WIDTH-1] == REG_MAX_LEN);
   assign wr_en   = psel && penable && pwrite && reg_hit;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (wr_en) begin
         max_len_ff <= pwdata[MAX_LEN_WIDTH-1:0];
      end
   end

   assign prdata = reg_hit ? {{(CSR_DATA_WIDTH-MAX_LEN_WIDTH){1'b0}}, max_len_ff}
                           : '0;

   always_comb begin
      if (max_len_ff < MAX_LEN_LOW) begin
         max_len_clamped = MAX_LEN_LOW;
      end else if (max_len_ff > MAX_LEN_HIGH) begin
         max_len_clamped = MAX_LEN_HIGH;
      end else begin
         max_len_clamped = max_len_ff;
      end
   end

   // kept characters per token: 1..255
   assign char_limit = 8'(max_len_clamped - 9'd1);

endmodule

### hdl/c_tok_lexer.sv
`include "c_source_tokenizer_macros.svh"

module c_tok_lexer
   import c_tok_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   byte_value,
   input  logic         at_end,
   input  logic [7:0]   char_limit,
   output tok_push_type push
);

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_SLASH,
      MODE_LINEC,
      MODE_BLOCKC,
      MODE_BSTAR,
      MODE_IDENT,
      MODE_STR,
      MODE_STRESC,
      MODE_PP,
      MODE_PPCR
   } mode_type;

   mode_type     mode_ff, mode_in, i_mode;
   logic         quote_ff, quote_in, i_quote;
   logic [7:0]   kept_ff, kept_in, i_kept, kept_inc;
   logic         i_v, pre_v, post_v, take_idle;
   tok_rslt_type i_r, pre_r, r0, r1;
   logic         is_alpha, is_ident, keep_ok;
   logic [7:0]   close_quote;

   assign is_alpha = byte_value inside {[CHAR_LOWER_A:CHAR_LOWER_Z],
                                        [CHAR_UPPER_A:CHAR_UPPER_Z], CHAR_UNDERSCORE};
   assign is_ident = is_alpha || (byte_value inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]});
   assign keep_ok  = kept_ff < char_limit;
   assign kept_inc = kept_ff + 8'd1;
   assign close_quote = quote_ff ? CHAR_DQUOTE : CHAR_SQUOTE;

   // byte seen between tokens
   always_comb begin
      i_mode  = MODE_IDLE;
      i_kept  = 8'd0;
      i_quote = quote_ff;
      i_v     = 1'b0;
      i_r     = '0;
      if (byte_value inside {CHAR_SPACE, CHAR_LF, CHAR_CR}) begin
         i_mode = MODE_IDLE;
      end else if (byte_value == CHAR_SLASH) begin
         i_mode = MODE_SLASH;
      end else if (is_alpha) begin
         i_mode = MODE_IDENT;
         i_kept = 8'd1;
         i_v    = 1'b1;
         i_r    = mk_rslt(byte_value, 1'b1, CLS_IDENT, 1'b1, 1'b0);
      end else if (byte_value inside {CHAR_SQUOTE, CHAR_DQUOTE}) begin
         i_mode  = MODE_STR;
         i_kept  = 8'd1;
         i_quote = (byte_value == CHAR_DQUOTE);
         i_v     = 1'b1;
         i_r     = mk_rslt(byte_value, 1'b1, CLS_STR, 1'b1, 1'b0);
      end else if (byte_value == CHAR_HASH) begin
         i_mode = MODE_PP;
         i_kept = 8'd1;
         i_v    = 1'b1;
         i_r    = mk_rslt(byte_value, 1'b1, CLS_PP, 1'b1, 1'b0);
      end else begin
         i_v = 1'b1;
         i_r = mk_rslt(byte_value, 1'b1, CLS_OTHER, 1'b1, 1'b1);
      end
   end

   // main transition
   always_comb begin
      mode_in   = mode_ff;
      kept_in   = kept_ff;
      quote_in  = quote_ff;
      pre_v     = 1'b0;
      pre_r     = '0;
      take_idle = 1'b0;
      if (at_end) begin
         case (mode_ff)
            MODE_SLASH: begin
               pre_v = 1'b1;
               pre_r = mk_rslt(CHAR_SLASH, 1'b1, CLS_OTHER, 1'b1, 1'b1);
            end
            MODE_IDENT: begin
               pre_v = 1'b1;
               pre_r = mk_rslt(CHAR_NUL, 1'b0, CLS_IDENT, 1'b0, 1'b1);
            end
            MODE_STR, MODE_STRESC: begin
               pre_v = 1'b1;
               pre_r = mk_rslt(CHAR_NUL, 1'b0, CLS_STR, 1'b0, 1'b1);
            end
            MODE_PP: begin
               pre_v = 1'b1;
               pre_r = mk_rslt(CHAR_NUL, 1'b0, CLS_PP, 1'b0, 1'b1);
            end
            default: ;
         endcase
         mode_in  = MODE_IDLE;
         quote_in = 1'b0;
         kept_in  = 8'd0;
      end else begin
         case (mode_ff)
            MODE_SLASH: begin
               if (byte_value == CHAR_SLASH) begin
                  mode_in = MODE_LINEC;
               end else if (byte_value == CHAR_STAR) begin
                  mode_in = MODE_BLOCKC;
               end else begin
                  pre_v     = 1'b1;
                  pre_r     = mk_rslt(CHAR_SLASH, 1'b1, CLS_OTHER, 1'b1, 1'b1);
                  take_idle = 1'b1;
               end
            end
            MODE_LINEC: begin
               take_idle = byte_value inside {CHAR_CR, CHAR_LF, CHAR_NUL};
            end
            MODE_BLOCKC: begin
               if (byte_value == CHAR_STAR) begin
                  mode_in = MODE_BSTAR;
               end
            end
            MODE_BSTAR: begin
               if (byte_value == CHAR_SLASH) begin
                  mode_in = MODE_IDLE;
               end else if (byte_value != CHAR_STAR) begin
                  mode_in = MODE_BLOCKC;
               end
            end
            MODE_IDENT: begin
               if (is_ident) begin
                  if (keep_ok) begin
                     kept_in = kept_inc;
                     pre_v   = 1'b1;
                     pre_r   = mk_rslt(byte_value, 1'b1, CLS_IDENT, 1'b0, 1'b0);
                  end
               end else begin
                  pre_v     = 1'b1;
                  pre_r     = mk_rslt(CHAR_NUL, 1'b0, CLS_IDENT, 1'b0, 1'b1);
                  take_idle = 1'b1;
               end
            end
            MODE_STR: begin
               if (byte_value == CHAR_BACKSLASH) begin
                  mode_in = MODE_STRESC;
                  if (keep_ok) begin
                     kept_in = kept_inc;
                     pre_v   = 1'b1;
                     pre_r   = mk_rslt(byte_value, 1'b1, CLS_STR, 1'b0, 1'b0);
                  end
               end else if (byte_value == close_quote) begin
                  // closing quote, or a bare close when out of room
                  pre_v   = 1'b1;
                  pre_r   = mk_rslt(byte_value, keep_ok, CLS_STR, 1'b0, 1'b1);
                  mode_in = MODE_IDLE;
                  kept_in = 8'd0;
               end else if (keep_ok) begin
                  kept_in = kept_inc;
                  pre_v   = 1'b1;
                  pre_r   = mk_rslt(byte_value, 1'b1, CLS_STR, 1'b0, 1'b0);
               end
            end
            MODE_STRESC: begin
               mode_in = MODE_STR;
               if (keep_ok) begin
                  kept_in = kept_inc;
                  pre_v   = 1'b1;
                  pre_r   = mk_rslt(byte_value, 1'b1, CLS_STR, 1'b0, 1'b0);
               end
            end
            MODE_PP: begin
               if (byte_value inside {CHAR_CR, CHAR_LF}) begin
                  pre_v   = 1'b1;
                  pre_r   = mk_rslt(CHAR_NUL, 1'b0, CLS_PP, 1'b0, 1'b1);
                  mode_in = (byte_value == CHAR_CR) ? MODE_PPCR : MODE_IDLE;
                  kept_in = 8'd0;
               end else if (keep_ok) begin
                  kept_in = kept_inc;
                  pre_v   = 1'b1;
                  pre_r   = mk_rslt(byte_value, 1'b1, CLS_PP, 1'b0, 1'b0);
               end
            end
            MODE_PPCR: begin
               mode_in = MODE_IDLE;
            end
            default: begin
               take_idle = 1'b1;
            end
         endcase
      end
      post_v = 1'b0;
      if (take_idle) begin
         mode_in  = i_mode;
         kept_in  = i_kept;
         quote_in = i_quote;
         post_v   = i_v;
      end
   end

   // pack: pre result first, then the one from the idle decode
   always_comb begin
      r0             = pre_v ? pre_r : i_r;
      r0.last_result = !(pre_v && post_v);
      r1             = i_r;
      r1.last_result = 1'b1;
      push.r0        = r0;
      push.r1        = r1;
      push.count     = accept ? (2'(pre_v) + 2'(post_v)) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         quote_ff <= 1'b0;
         kept_ff  <= 8'd0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         quote_ff <= quote_in;
         kept_ff  <= kept_in;
      end
   end

   // outside tokens nothing is counted
   `CTOK_ASSERT(a_kept_clear_outside_token, clock, reset,
      (mode_ff == MODE_IDLE || mode_ff == MODE_SLASH || mode_ff == MODE_LINEC ||
       mode_ff == MODE_BLOCKC || mode_ff == MODE_BSTAR || mode_ff == MODE_PPCR)
      |-> (kept_ff == 8'd0))
   // end of input returns everything to reset
   `CTOK_ASSERT(a_end_resets_state, clock, reset,
      (accept && at_end) |=> (mode_ff == MODE_IDLE && kept_ff == 8'd0 && !quote_ff))
   // two results only when a pending slash or identifier is flushed
   `CTOK_ASSERT(a_pair_source, clock, reset,
      (push.count == 2'd2) |-> (mode_ff == MODE_SLASH || mode_ff == MODE_IDENT))

endmodule

### hdl/c_tok_queue.sv
`include "c_source_tokenizer_macros.svh"

module c_tok_queue
   import c_tok_pkg::*;
#(
   parameter int Depth = RESULT_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  tok_push_type push,
   output logic         room_low,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output tok_rslt_type head
);

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);

   tok_rslt_type      entries_ff [Depth];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              pop;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
   endfunction

   assign wr_ptr_nx = ptr_inc(wr_ptr_ff);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];
   // stall intake unless two slots are free
   assign room_low  = (count_ff > CW'(Depth - 2));

   always_comb begin
      case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_nx;
         2'd2:    wr_ptr_in = ptr_inc(wr_ptr_nx);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_nx] <= push.r1;
      end
   end

   `CTOK_ASSERT(a_no_overfill, clock, reset,
      (32'(count_ff) + 32'(push.count)) <= 32'(Depth))
   `CTOK_NEVER(a_no_push_when_low, clock, reset,
      room_low && (push.count != 2'd0))

endmodule

### hdl/c_source_tokenizer.sv
// Results are registered in the result queue before they are offered on rsp_*.
// Throughput: one input beat per cycle while rsp_stall is low and each byte yields at
//   most one result; a byte flushing a slash or identifier yields two output beats.
// Intake stalls when fewer than two result-queue slots are free.
// Reset (synchronous, active high): lexer idle, queue empty, max_token_length = 100.
module c_source_tokenizer
   import c_tok_pkg::*;
#(
   parameter int QueueDepth = RESULT_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   // input byte channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_byte_value,
   input  logic                      req_at_end,
   // token result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_char_out,
   output logic                      rsp_has_char,
   output logic [1:0]                rsp_token_class,
   output logic                      rsp_first_of_token,
   output logic                      rsp_last_of_token,
   output logic                      rsp_last_result,
   // register port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic         req_accept;
   logic [7:0]   char_limit;
   logic         room_low;
   tok_push_type push;
   tok_rslt_type head;

   // stall depends only on queue fill and reset, never on req_valid;
   // no beat is taken while reset is high
   assign req_stall  = room_low || reset;
   assign req_accept = req_valid && !req_stall;

   // max_token_length register, clamped to a kept-character limit
   c_tok_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .char_limit (char_limit)
   );

   // lexer state and combinational transition; up to two results per beat
   c_tok_lexer u_lexer (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .byte_value (req_byte_value),
      .at_end     (req_at_end),
      .char_limit (char_limit),
      .push       (push)
   );

   // result queue parts intake from the output handshake
   c_tok_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room_low  (room_low),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_char_out       = head.char_out;
   assign rsp_has_char       = head.has_char;
   assign rsp_token_class    = head.token_class;
   assign rsp_first_of_token = head.first_of_token;
   assign rsp_last_of_token  = head.last_of_token;
   assign rsp_last_result    = head.last_result;

endmodule

### tb/sv/c_source_tokenizer_tb.sv
module c_source_tokenizer_tb;
   import c_tok_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // run ends here whatever happens; the slowest legal run is far below it
   localparam int CYCLE_LIMIT = 400000;
   // bytes of random fragments queued per register setting
   localparam int PHASE_BYTES = 90;

   // lexer modes of the local predictor
   typedef enum logic [3:0] {
      LX_IDLE, LX_SLASH, LX_LINE_CMT, LX_BLOCK_CMT, LX_BLOCK_STAR,
      LX_IDENT, LX_LIT, LX_LIT_ESC, LX_PP, LX_PP_CR
   } lex_mode_type;

   // one source beat waiting to be offered
   typedef struct packed {
      logic [7:0] value;
      logic       eoi;
   } src_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid      = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_byte_value = '0;
   logic                      req_at_end     = 1'b0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [7:0]                rsp_char_out;
   logic                      rsp_has_char;
   logic [1:0]                rsp_token_class;
   logic                      rsp_first_of_token;
   logic                      rsp_last_of_token;
   logic                      rsp_last_result;

   logic                      psel    = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   c_source_tokenizer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_value     (req_byte_value),
      .req_at_end         (req_at_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_char_out       (rsp_char_out),
      .rsp_has_char       (rsp_has_char),
      .rsp_token_class    (rsp_token_class),
      .rsp_first_of_token (rsp_first_of_token),
      .rsp_last_of_token  (rsp_last_of_token),
      .rsp_last_result    (rsp_last_result),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shared state
   // ------------------------------------------------------------------
   src_beat_type source_beats[$];   // bytes not yet offered to the block
   tok_rslt_type tokens_due[$];     // predicted results, oldest first
   tok_rslt_type step_toks[$];      // results of the byte being predicted

   int  errors    = 0;
   int  cycles    = 0;
   int  beats_in  = 0;              // input beats taken so far
   int  queued    = 0;              // bytes queued in this phase, paces the phases
   int  gap_pct   = 36;             // sender idle chance, percent
   int  stall_pct = 36;             // receiver stall chance, percent

   // long receiver hold-off, once, in its own process
   logic hold_on   = 1'b0;
   bit   hold_done = 1'b0;
   int   hold_left = 0;

   // predictor copy of the register and the lexer state
   logic [8:0]   cfg_max_len = MAX_LEN_RESET;
   lex_mode_type lx_mode     = LX_IDLE;
   bit           lx_dq       = 1'b0;
   logic [7:0]   lx_kept     = '0;

   task automatic report(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
   endtask

   // ------------------------------------------------------------------
   // Token predictor
   // ------------------------------------------------------------------
   function automatic bit is_alpha(input logic [7:0] b);
      return (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) ||
             (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) || b == CHAR_UNDERSCORE;
   endfunction

   function automatic bit is_word_char(input logic [7:0] b);
      return is_alpha(b) || (b >= CHAR_DIGIT_0 && b <= CHAR_DIGIT_9);
   endfunction

   function automatic void emit_tok(input logic [7:0] ch, input logic has,
                                    input logic [1:0] cls, input logic first,
                                    input logic last);
      tok_rslt_type t;
      t.char_out       = has ? ch : 8'h00;
      t.has_char       = has;
      t.token_class    = cls;
      t.first_of_token = first;
      t.last_of_token  = last;
      t.last_result    = 1'b0;
      step_toks.push_back(t);
   endfunction

   // counts one more kept character if the buffer has room
   function automatic bit take_char();
      logic [8:0] m;
      m = cfg_max_len;
      if (m < MAX_LEN_LOW) m = MAX_LEN_LOW;
      if (m > MAX_LEN_HIGH) m = MAX_LEN_HIGH;
      if (lx_kept < 8'(m - 9'd1)) begin
         lx_kept++;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // a byte seen between tokens
   function automatic void open_token(input logic [7:0] b);
      lx_mode = LX_IDLE;
      lx_kept = '0;
      if (b == CHAR_SPACE || b == CHAR_LF || b == CHAR_CR) return;
      if (b == CHAR_SLASH) begin
         lx_mode = LX_SLASH;
      end else if (is_alpha(b)) begin
         lx_kept = 8'd1;
         lx_mode = LX_IDENT;
         emit_tok(b, 1'b1, CLS_IDENT, 1'b1, 1'b0);
      end else if (b == CHAR_SQUOTE || b == CHAR_DQUOTE) begin
         lx_kept = 8'd1;
         lx_dq   = (b == CHAR_DQUOTE);
         lx_mode = LX_LIT;
         emit_tok(b, 1'b1, CLS_STR, 1'b1, 1'b0);
      end else if (b == CHAR_HASH) begin
         lx_kept = 8'd1;
         lx_mode = LX_PP;
         emit_tok(b, 1'b1, CLS_PP, 1'b1, 1'b0);
      end else begin
         emit_tok(b, 1'b1, CLS_OTHER, 1'b1, 1'b1);
      end
   endfunction

   // advance the lexer by one accepted beat and queue what it gives out
   function automatic void tokenise_byte(input logic [7:0] b, input logic eoi);
      tok_rslt_type t;
      step_toks.delete();
      if (eoi) begin
         case (lx_mode)
            LX_SLASH:          emit_tok(CHAR_SLASH, 1'b1, CLS_OTHER, 1'b1, 1'b1);
            LX_IDENT:          emit_tok(8'h00, 1'b0, CLS_IDENT, 1'b0, 1'b1);
            LX_LIT, LX_LIT_ESC: emit_tok(8'h00, 1'b0, CLS_STR, 1'b0, 1'b1);
            LX_PP:             emit_tok(8'h00, 1'b0, CLS_PP, 1'b0, 1'b1);
            default: ;
         endcase
         lx_mode = LX_IDLE;
         lx_dq   = 1'b0;
         lx_kept = '0;
      end else begin
         case (lx_mode)
            LX_SLASH: begin
               if (b == CHAR_SLASH) lx_mode = LX_LINE_CMT;
               else if (b == CHAR_STAR) lx_mode = LX_BLOCK_CMT;
               else begin
                  emit_tok(CHAR_SLASH, 1'b1, CLS_OTHER, 1'b1, 1'b1);
                  open_token(b);
               end
            end
            LX_LINE_CMT: begin
               if (b == CHAR_CR || b == CHAR_LF || b == CHAR_NUL) open_token(b);
            end
            LX_BLOCK_CMT: begin
               if (b == CHAR_STAR) lx_mode = LX_BLOCK_STAR;
            end
            LX_BLOCK_STAR: begin
               if (b == CHAR_SLASH) lx_mode = LX_IDLE;
               else if (b != CHAR_STAR) lx_mode = LX_BLOCK_CMT;
            end
            LX_IDENT: begin
               if (is_word_char(b)) begin
                  if (take_char()) emit_tok(b, 1'b1, CLS_IDENT, 1'b0, 1'b0);
               end else begin
                  emit_tok(8'h00, 1'b0, CLS_IDENT, 1'b0, 1'b1);
                  open_token(b);
               end
            end
            LX_LIT: begin
               if (b == CHAR_BACKSLASH) begin
                  if (take_char()) emit_tok(b, 1'b1, CLS_STR, 1'b0, 1'b0);
                  lx_mode = LX_LIT_ESC;
               end else if (b == (lx_dq ? CHAR_DQUOTE : CHAR_SQUOTE)) begin
                  if (take_char()) emit_tok(b, 1'b1, CLS_STR, 1'b0, 1'b1);
                  else emit_tok(8'h00, 1'b0, CLS_STR, 1'b0, 1'b1);
                  lx_mode = LX_IDLE;
                  lx_kept = '0;
               end else if (take_char()) begin
                  emit_tok(b, 1'b1, CLS_STR, 1'b0, 1'b0);
               end
            end
            LX_LIT_ESC: begin
               if (take_char()) emit_tok(b, 1'b1, CLS_STR, 1'b0, 1'b0);
               lx_mode = LX_LIT;
            end
            LX_PP: begin
               if (b == CHAR_CR || b == CHAR_LF) begin
                  emit_tok(8'h00, 1'b0, CLS_PP, 1'b0, 1'b1);
                  lx_mode = (b == CHAR_CR) ? LX_PP_CR : LX_IDLE;
                  lx_kept = '0;
               end else if (take_char()) begin
                  emit_tok(b, 1'b1, CLS_PP, 1'b0, 1'b0);
               end
            end
            LX_PP_CR: lx_mode = LX_IDLE;   // byte after the CR is swallowed
            default:  open_token(b);
         endcase
      end
      if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last_result = 1'b1;
      foreach (step_toks[i]) begin
         t = step_toks[i];
         tokens_due.push_back(t);
      end
   endfunction

   // ------------------------------------------------------------------
   // Input driver: offers queued bytes, holds each until taken.
   // The idle decision is made only when nothing is on offer, so valid
   // never reacts to stall.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : byte_driver
      bit           offering;
      src_beat_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offering = req_valid;
         if (req_valid && !req_stall) begin
            tokenise_byte(req_byte_value, req_at_end);
            beats_in <= beats_in + 1;
            offering = 1'b0;
         end
         if (!offering) begin
            if (source_beats.size() > 0 && $urandom_range(99) >= gap_pct) begin
               nxt = source_beats.pop_front();
               req_valid      <= 1'b1;
               req_byte_value <= nxt.value;
               req_at_end     <= nxt.eoi;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result monitor: checks each taken beat against the oldest
   // prediction, field by field, and drives the random stall.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : token_monitor
      tok_rslt_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tokens_due.size() == 0) begin
            report($sformatf("unexpected result beat char %02h class %0d",
                             rsp_char_out, rsp_token_class));
         end else begin
            want = tokens_due.pop_front();
            if (rsp_char_out !== want.char_out)
               report($sformatf("char_out %02h, expected %02h",
                                rsp_char_out, want.char_out));
            if (rsp_has_char !== want.has_char)
               report($sformatf("has_char %0b, expected %0b",
                                rsp_has_char, want.has_char));
            if (rsp_token_class !== want.token_class)
               report($sformatf("token_class %0d, expected %0d",
                                rsp_token_class, want.token_class));
            if (rsp_first_of_token !== want.first_of_token)
               report($sformatf("first_of_token %0b, expected %0b",
                                rsp_first_of_token, want.first_of_token));
            if (rsp_last_of_token !== want.last_of_token)
               report($sformatf("last_of_token %0b, expected %0b",
                                rsp_last_of_token, want.last_of_token));
            if (rsp_last_result !== want.last_result)
               report($sformatf("last_result %0b, expected %0b",
                                rsp_last_result, want.last_result));
         end
      end
      rsp_stall <= hold_on || ($urandom_range(99) < stall_pct);
   end

   // one long hold-off on the result side while the sender keeps going,
   // so the result queue fills and intake has to stall
   always @(posedge clock) begin : result_holdoff
      if (reset) begin
         hold_on   <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         if (hold_left == 1) hold_on <= 1'b0;
      end else if (!hold_done && beats_in >= 250) begin
         hold_on   <= 1'b1;
         hold_left <= 90;
         hold_done <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin : watchdog
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic put_byte(input logic [7:0] b);
      source_beats.push_back('{value: b, eoi: 1'b0});
      queued++;
   endtask

   // end of input; the byte is don't-care so it is random
   task automatic put_end();
      source_beats.push_back('{value: 8'($urandom), eoi: 1'b1});
      queued++;
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   function automatic logic [7:0] rand_alpha();
      int r;
      r = $urandom_range(52);
      if (r < 26) return CHAR_LOWER_A + 8'(r);
      if (r < 52) return CHAR_UPPER_A + 8'(r - 26);
      return CHAR_UNDERSCORE;
   endfunction

   function automatic logic [7:0] rand_print();
      return 8'($urandom_range(32, 126));
   endfunction

   // most tokens short, the odd one long enough to reach or overrun the largest buffer
   function automatic int rand_len(input int short_max);
      if ($urandom_range(149) == 0) return $urandom_range(250, 270);
      return $urandom_range(short_max);
   endfunction

   // one C fragment with random content, some noise, or an end of input
   task automatic put_fragment();
      int          n;
      logic [7:0]  q;
      string       ops;
      ops = "+-*=<>(){}[];,.!&|^~?:%\t";
      case ($urandom_range(11))
         0, 1: begin   // identifier
            put_byte(rand_alpha());
            n = rand_len(8);
            for (int i = 0; i < n; i++)
               put_byte(($urandom_range(3) == 0) ? 8'(CHAR_DIGIT_0 + $urandom_range(9))
                                                 : rand_alpha());
         end
         2: begin      // string or char literal, escapes now and then
            q = $urandom_range(1) ? CHAR_DQUOTE : CHAR_SQUOTE;
            put_byte(q);
            n = rand_len(6);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(5) == 0) begin
                  put_byte(CHAR_BACKSLASH);
                  put_byte($urandom_range(1) ? q : rand_print());
               end else begin
                  put_byte(rand_print());
               end
            end
            if ($urandom_range(9) != 0) put_byte(q);
         end
         3: begin      // preprocessor line
            put_byte(CHAR_HASH);
            n = rand_len(10);
            for (int i = 0; i < n; i++) put_byte(rand_print());
            if ($urandom_range(1)) begin
               put_byte(CHAR_CR);
               put_byte(8'($urandom));   // swallowed
            end else begin
               put_byte(CHAR_LF);
            end
         end
         4: begin      // line comment, ended by LF, CR or NUL
            put_byte(CHAR_SLASH);
            put_byte(CHAR_SLASH);
            n = $urandom_range(8);
            for (int i = 0; i < n; i++) put_byte(rand_print());
            case ($urandom_range(2))
               0:       put_byte(CHAR_LF);
               1:       put_byte(CHAR_CR);
               default: put_byte(CHAR_NUL);
            endcase
         end
         5: begin      // block comment, star runs included
            put_byte(CHAR_SLASH);
            put_byte(CHAR_STAR);
            n = $urandom_range(8);
            for (int i = 0; i < n; i++)
               put_byte($urandom_range(3) == 0 ? CHAR_STAR : rand_print());
            if ($urandom_range(1)) put_byte(CHAR_STAR);
            put_byte(CHAR_STAR);
            put_byte(CHAR_SLASH);
         end
         6: begin      // blanks
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               case ($urandom_range(2))
                  0:       put_byte(CHAR_SPACE);
                  1:       put_byte(CHAR_LF);
                  default: put_byte(CHAR_CR);
               endcase
         end
         7: put_byte(ops[$urandom_range(ops.len() - 1)]);
         8: begin      // number: digits come out as single other tokens
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) put_byte(8'(CHAR_DIGIT_0 + $urandom_range(9)));
         end
         9: begin      // raw noise over the whole byte range
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) put_byte(8'($urandom));
         end
         10: begin     // slash followed by anything
            put_byte(CHAR_SLASH);
            put_byte(8'($urandom));
         end
         default: if ($urandom_range(2) == 0) put_end();
      endcase
      if ($urandom_range(2) == 0) put_byte(CHAR_SPACE);
   endtask

   // wait until every byte is taken and every result has come, then let
   // the pipeline settle in case the last byte gave none
   task automatic wait_drained();
      do @(negedge clock);
      while (source_beats.size() != 0 || req_valid || tokens_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_max_len(input logic [8:0] len);
      logic [CSR_DATA_WIDTH-1:0] word;
      word = ($urandom & ~CSR_DATA_WIDTH'(9'h1FF)) | CSR_DATA_WIDTH'(len);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_WIDTH'(4 * REG_MAX_LEN);
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      cfg_max_len = word[8:0];
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Sequence: reset, directed bytes and a random fragment phase at the
   // reset setting, then one such phase per register setting. Every phase
   // boundary is a full drain; the sender waits until all results are in.
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic [8:0] settings[$];
      settings = '{9'd2, 9'd256, 9'd0, 9'd1, 9'd511,
                   9'($urandom_range(3, 12)), 9'd300, 9'($urandom_range(2, 256))};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: word closed by an operator, preprocessor line closed by
      // CR with the next byte swallowed, escaped quote inside a literal,
      // lone slash, line comment closed by NUL, star run before the slash,
      // tab, top byte value, lone slash at end of input
      put_text("ab9_+#d");
      put_byte(CHAR_CR);
      put_byte(8'h51);
      put_byte(CHAR_DQUOTE);
      put_byte(CHAR_BACKSLASH);
      put_byte(CHAR_DQUOTE);
      put_byte(CHAR_DQUOTE);
      put_text("/x//c");
      put_byte(CHAR_NUL);
      put_text("/***/\t");
      put_byte(8'hFF);
      put_byte(CHAR_SLASH);
      put_end();
      queued = 0;
      while (queued < PHASE_BYTES) put_fragment();

      foreach (settings[p]) begin
         wait_drained();
         write_max_len(settings[p]);
         // one calm stretch with no gaps and no stalls at all
         gap_pct   = (p == 4) ? 0 : 36;
         stall_pct = (p == 4) ? 0 : 36;
         if (p == 0) begin
            // one-character buffer: closing quote finds no room, open
            // token closed by end of input
            put_text("'ab' \"\" xy#q");
            put_end();
         end
         queued = 0;
         while (queued < PHASE_BYTES) put_fragment();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### c_source_tokenizer.f
+incdir+hdl
hdl/c_tok_pkg.sv
hdl/c_tok_csr.sv
hdl/c_tok_lexer.sv
hdl/c_tok_queue.sv
hdl/c_source_tokenizer.sv
tb/sv/c_source_tokenizer_tb.sv
